>>> rtl/core/sbd_pkg.sv
// Shared types, codes and CRC helper for the servo bus packet deframer.
`default_nettype none

package sbd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_BYTE0 = 3'd0,
    REG_HEADER_BYTE1 = 3'd1,
    REG_HEADER_BYTE2 = 3'd2,
    REG_HEADER_BYTE3 = 3'd3,
    REG_CRC_POLY     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_HEADER   = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_TIMEOUT = 1'b1
  } in_kind_t;

  typedef enum logic {
    RES_PARAM = 1'b0,
    RES_END   = 1'b1
  } res_kind_t;

  localparam logic [7:0]  HeaderByte0Rst = 8'hFF;
  localparam logic [7:0]  HeaderByte1Rst = 8'hFF;
  localparam logic [7:0]  HeaderByte2Rst = 8'hFD;
  localparam logic [7:0]  HeaderByte3Rst = 8'h00;
  localparam logic [15:0] CrcPolyRst     = 16'h8005;

  // CRC table entry for index idx under polynomial poly (MSB-first, 8 shifts).
  function automatic logic [15:0] crc_table_entry(input logic [7:0] idx,
                                                  input logic [15:0] poly);
    logic [15:0] v;
    v = {idx, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ poly;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sbd_if.sv
// Valid/ready stream interfaces for deframer input items and results.
`default_nettype none

interface sbd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sbd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  param_byte;
  logic [7:0]  packet_id;
  logic [7:0]  instruction;
  logic [15:0] frame_length;
  logic [15:0] param_count;
  logic [1:0]  status;

  modport source (output valid, output result_kind, output param_byte, output packet_id,
                  output instruction, output frame_length, output param_count,
                  output status, input ready);
  modport sink   (input valid, input result_kind, input param_byte, input packet_id,
                  input instruction, input frame_length, input param_count,
                  input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sbd_crc.sv
// One-byte CRC-16 update, table entry built from the programmable polynomial.
`default_nettype none

module sbd_crc
  import sbd_pkg::*;
(
  input  wire logic [15:0] crc,
  input  wire logic [7:0]  data,
  input  wire logic [15:0] poly,
  output logic      [15:0] crc_next
);

  logic [7:0] idx;

  assign idx      = crc[15:8] ^ data;
  assign crc_next = {crc[7:0], 8'h00} ^ crc_table_entry(idx, poly);

endmodule

`default_nettype wire

>>> rtl/core/servo_bus_packet_deframer.sv
// Top level: servo bus packet deframer with input register and result register.
// An item is registered at acceptance and its result, if any, is loaded into the
//   result register when it is processed. Throughput: one item per cycle unless
//   a held result stalls the pipe; the phase/CRC update is one pass of logic.
// Reset (rst, synchronous): hunting for the first header byte, packet state
//   zero, header bytes FF FF FD 00, CRC polynomial 0x8005, both stages empty.
`default_nettype none

module servo_bus_packet_deframer
  import sbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                write_en,
  input  wire logic [CfgIdxW-1:0]  reg_index,
  input  wire logic [CfgDataW-1:0] write_data,
  sbd_in_if.sink                   rx,
  sbd_out_if.source                result
);

  // Receive phases, one-hot.
  typedef enum logic [10:0] {
    PH_H0     = 11'b000_0000_0001,
    PH_H1     = 11'b000_0000_0010,
    PH_H2     = 11'b000_0000_0100,
    PH_H3     = 11'b000_0000_1000,
    PH_ID     = 11'b000_0001_0000,
    PH_LEN_L  = 11'b000_0010_0000,
    PH_LEN_H  = 11'b000_0100_0000,
    PH_INSTR  = 11'b000_1000_0000,
    PH_PARAM  = 11'b001_0000_0000,
    PH_CRC_L  = 11'b010_0000_0000,
    PH_CRC_H  = 11'b100_0000_0000
  } phase_t;

  // Configuration registers.
  logic [7:0]  header_byte0, header_byte1, header_byte2, header_byte3;
  logic [15:0] crc_poly;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte0 <= HeaderByte0Rst;
      header_byte1 <= HeaderByte1Rst;
      header_byte2 <= HeaderByte2Rst;
      header_byte3 <= HeaderByte3Rst;
      crc_poly     <= CrcPolyRst;
    end else if (write_en) begin
      case (reg_index)
        REG_HEADER_BYTE0: header_byte0 <= write_data[7:0];
        REG_HEADER_BYTE1: header_byte1 <= write_data[7:0];
        REG_HEADER_BYTE2: header_byte2 <= write_data[7:0];
        REG_HEADER_BYTE3: header_byte3 <= write_data[7:0];
        REG_CRC_POLY:     crc_poly     <= write_data;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  // Pipeline control. The whole pipe moves when the result register is
  // empty or being drained; the input register can also fill while empty.
  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;
  logic       advance;
  logic       process;

  assign advance  = !result.valid || result.ready;
  assign process  = in_valid && advance;
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_kind <= rx.kind;
      in_byte <= rx.rx_byte;
    end
  end

  // Packet state.
  phase_t      phase, phase_next;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [7:0]  instr_reg, instr_reg_next;
  logic [15:0] remaining, remaining_next;
  logic [1:0]  repeat_run, repeat_run_next;
  logic [15:0] crc_sum, crc_sum_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] kept_count, kept_count_next;

  logic [15:0] crc_fed;

  sbd_crc u_crc (
    .crc      (crc_sum),
    .data     (in_byte),
    .poly     (crc_poly),
    .crc_next (crc_fed)
  );

  // Result produced by the current item.
  logic        emit;
  res_kind_t   emit_kind;
  logic [7:0]  emit_param;
  logic [15:0] emit_count;
  status_t     emit_status;
  logic        clear_pkt;

  logic [7:0]  expect_byte;
  logic [15:0] rem_dec;
  logic [15:0] rx_crc;

  assign rem_dec = 16'(remaining - 16'd1);
  assign rx_crc  = {in_byte, crc_low_byte};

  always_comb begin
    case (phase)
      PH_H0:   expect_byte = header_byte0;
      PH_H1:   expect_byte = header_byte1;
      PH_H2:   expect_byte = header_byte2;
      default: expect_byte = header_byte3;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    id_reg_next       = id_reg;
    length_reg_next   = length_reg;
    instr_reg_next    = instr_reg;
    remaining_next    = remaining;
    repeat_run_next   = repeat_run;
    crc_sum_next      = crc_sum;
    crc_low_byte_next = crc_low_byte;
    kept_count_next   = kept_count;
    emit              = 1'b0;
    emit_kind         = RES_END;
    emit_param        = 8'h00;
    emit_count        = kept_count;
    emit_status       = ST_OK;
    clear_pkt         = 1'b0;

    if (in_kind == KIND_TIMEOUT) begin
      emit        = 1'b1;
      emit_status = ST_TIMEOUT;
      clear_pkt   = 1'b1;
    end else begin
      case (phase)
        PH_H0, PH_H1, PH_H2, PH_H3: begin
          if (in_byte != expect_byte) begin
            // mismatch drops the byte and restarts hunting
            emit        = 1'b1;
            emit_status = ST_HEADER;
            clear_pkt   = 1'b1;
          end else begin
            crc_sum_next = crc_fed;
            case (phase)
              PH_H0:   phase_next = PH_H1;
              PH_H1:   phase_next = PH_H2;
              PH_H2:   phase_next = PH_H3;
              default: phase_next = PH_ID;
            endcase
          end
        end
        PH_ID: begin
          crc_sum_next = crc_fed;
          id_reg_next  = in_byte;
          phase_next   = PH_LEN_L;
        end
        PH_LEN_L: begin
          crc_sum_next    = crc_fed;
          length_reg_next = {8'h00, in_byte};
          phase_next      = PH_LEN_H;
        end
        PH_LEN_H: begin
          crc_sum_next    = crc_fed;
          length_reg_next = {in_byte, length_reg[7:0]};
          phase_next      = PH_INSTR;
        end
        PH_INSTR: begin
          crc_sum_next   = crc_fed;
          instr_reg_next = in_byte;
          if (length_reg > 16'd3) begin
            remaining_next  = 16'(length_reg - 16'd3);
            repeat_run_next = 2'd0;
            phase_next      = PH_PARAM;
          end else begin
            // short length: no parameters, CRC follows
            remaining_next = 16'd0;
            phase_next     = PH_CRC_L;
          end
        end
        PH_PARAM: begin
          crc_sum_next   = crc_fed;
          remaining_next = rem_dec;
          if (rem_dec == 16'd0) begin
            phase_next = PH_CRC_L;
          end
          if (in_byte == header_byte2 && repeat_run == 2'd2) begin
            // stuff byte: dropped, run restarts (wins over a run byte)
            repeat_run_next = 2'd0;
          end else begin
            if (in_byte == header_byte0) begin
              if (repeat_run != 2'd2) begin
                repeat_run_next = 2'(repeat_run + 2'd1);
              end
            end else begin
              repeat_run_next = 2'd0;
            end
            kept_count_next = 16'(kept_count + 16'd1);
            emit            = 1'b1;
            emit_kind       = RES_PARAM;
            emit_param      = in_byte;
            emit_count      = kept_count_next;
          end
        end
        PH_CRC_L: begin
          crc_low_byte_next = in_byte;
          phase_next        = PH_CRC_H;
        end
        default: begin
          emit        = 1'b1;
          emit_status = (rx_crc == crc_sum) ? ST_OK : ST_CHECKSUM;
          clear_pkt   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_H0;
      id_reg       <= 8'h00;
      length_reg   <= 16'h0000;
      instr_reg    <= 8'h00;
      remaining    <= 16'h0000;
      repeat_run   <= 2'd0;
      crc_sum      <= 16'h0000;
      crc_low_byte <= 8'h00;
      kept_count   <= 16'h0000;
    end else if (process) begin
      if (clear_pkt) begin
        // every end report leaves the packet state cleared
        phase        <= PH_H0;
        id_reg       <= 8'h00;
        length_reg   <= 16'h0000;
        instr_reg    <= 8'h00;
        remaining    <= 16'h0000;
        repeat_run   <= 2'd0;
        crc_sum      <= 16'h0000;
        crc_low_byte <= 8'h00;
        kept_count   <= 16'h0000;
      end else begin
        phase        <= phase_next;
        id_reg       <= id_reg_next;
        length_reg   <= length_reg_next;
        instr_reg    <= instr_reg_next;
        remaining    <= remaining_next;
        repeat_run   <= repeat_run_next;
        crc_sum      <= crc_sum_next;
        crc_low_byte <= crc_low_byte_next;
        kept_count   <= kept_count_next;
      end
    end
  end

  // Result register: reloads whenever the pipe advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      result.result_kind  <= emit_kind;
      result.param_byte   <= emit_param;
      result.packet_id    <= id_reg;
      result.instruction  <= instr_reg;
      result.frame_length <= length_reg;
      result.param_count  <= emit_count;
      result.status       <= emit_status;
    end
  end

endmodule

`default_nettype wire

>>> test/servo_bus_packet_deframer_tb.sv
// Self-checking testbench for the servo bus packet deframer: framed traffic, noise and timeouts.
`timescale 1ns / 100ps

import sbd_pkg::*;

// Receive phases of the predictor, in wire order.
typedef enum logic [3:0] {
  RX_HDR0, RX_HDR1, RX_HDR2, RX_HDR3, RX_ID, RX_LEN_LO, RX_LEN_HI, RX_INSTR,
  RX_PARAM, RX_CRC_LO, RX_CRC_HI
} rx_phase_t;

typedef struct {
  res_kind_t   kind;
  logic [7:0]  param_byte;
  logic [7:0]  packet_id;
  logic [7:0]  instruction;
  logic [15:0] frame_length;
  logic [15:0] param_count;
  status_t     status;
} deframe_result_t;

// One byte of the MSB-first CRC-16, worked bit by bit.
function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b,
                                           logic [15:0] poly);
  logic [15:0] c;
  c = crc ^ {b, 8'h00};
  for (int k = 0; k < 8; k++) begin
    c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
  end
  return c;
endfunction

class deframe_scoreboard;
  logic [7:0]      hdr [4];
  logic [15:0]     poly;
  rx_phase_t       ph;
  logic [7:0]      id_q, instr_q, crc_lo_q;
  logic [15:0]     len_q, left_q, crc_q, kept_q;
  logic [1:0]      run_q;
  deframe_result_t due_results[$];
  int              bad_count;
  int              param_seen;
  int              status_seen [4];

  function new();
    hdr[0] = HeaderByte0Rst;
    hdr[1] = HeaderByte1Rst;
    hdr[2] = HeaderByte2Rst;
    hdr[3] = HeaderByte3Rst;
    poly = CrcPolyRst;
    bad_count = 0;
    param_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_packet();
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_HEADER_BYTE0: hdr[0] = data[7:0];
      REG_HEADER_BYTE1: hdr[1] = data[7:0];
      REG_HEADER_BYTE2: hdr[2] = data[7:0];
      REG_HEADER_BYTE3: hdr[3] = data[7:0];
      REG_CRC_POLY:     poly = data;
      default: ;
    endcase
  endfunction

  function void clear_packet();
    ph = RX_HDR0;
    id_q = '0;
    instr_q = '0;
    crc_lo_q = '0;
    len_q = '0;
    left_q = '0;
    crc_q = '0;
    kept_q = '0;
    run_q = '0;
  endfunction

  function void push_result(res_kind_t k, logic [7:0] pb, status_t st);
    deframe_result_t r;
    r.kind = k;
    r.param_byte = pb;
    r.packet_id = id_q;
    r.instruction = instr_q;
    r.frame_length = len_q;
    r.param_count = kept_q;
    r.status = st;
    due_results.push_back(r);
  endfunction

  function void end_packet(status_t st);
    push_result(RES_END, 8'h00, st);
    clear_packet();
  endfunction

  function void take_rx_item(in_kind_t k, logic [7:0] b);
    if (k == KIND_TIMEOUT) begin
      end_packet(ST_TIMEOUT);
      return;
    end
    case (ph)
      RX_HDR0, RX_HDR1, RX_HDR2, RX_HDR3: begin
        if (b != hdr[ph[1:0]]) begin
          end_packet(ST_HEADER);
        end else begin
          crc_q = crc16_next(crc_q, b, poly);
          ph = rx_phase_t'(ph + 1);
        end
      end
      RX_ID: begin
        crc_q = crc16_next(crc_q, b, poly);
        id_q = b;
        ph = RX_LEN_LO;
      end
      RX_LEN_LO: begin
        crc_q = crc16_next(crc_q, b, poly);
        len_q = {8'h00, b};
        ph = RX_LEN_HI;
      end
      RX_LEN_HI: begin
        crc_q = crc16_next(crc_q, b, poly);
        len_q[15:8] = b;
        ph = RX_INSTR;
      end
      RX_INSTR: begin
        crc_q = crc16_next(crc_q, b, poly);
        instr_q = b;
        if (len_q > 16'd3) begin
          left_q = len_q - 16'd3;
          run_q = '0;
          ph = RX_PARAM;
        end else begin
          left_q = '0;
          ph = RX_CRC_LO;
        end
      end
      RX_PARAM: begin
        crc_q = crc16_next(crc_q, b, poly);
        left_q = left_q - 16'd1;
        if (left_q == 16'd0) ph = RX_CRC_LO;
        if (b == hdr[2] && run_q >= 2'd2) begin
          run_q = '0;
        end else begin
          if (b == hdr[0]) begin
            if (run_q < 2'd2) run_q = run_q + 2'd1;
          end else begin
            run_q = '0;
          end
          kept_q = kept_q + 16'd1;
          push_result(RES_PARAM, b, ST_OK);
        end
      end
      RX_CRC_LO: begin
        crc_lo_q = b;
        ph = RX_CRC_HI;
      end
      default: end_packet(({b, crc_lo_q} == crc_q) ? ST_OK : ST_CHECKSUM);
    endcase
  endfunction

  function string fmt(deframe_result_t r);
    return $sformatf("kind=%0d byte=%h id=%h instr=%h len=%h count=%h status=%0d",
                     r.kind, r.param_byte, r.packet_id, r.instruction,
                     r.frame_length, r.param_count, r.status);
  endfunction

  function void check_result(deframe_result_t got);
    deframe_result_t want;
    if (due_results.size() == 0) begin
      bad_count++;
      if (bad_count <= 10) $display("ERROR: result with none due: %s", fmt(got));
      return;
    end
    want = due_results.pop_front();
    if (want.kind == RES_PARAM) param_seen++;
    else status_seen[want.status]++;
    if (got.kind !== want.kind || got.param_byte !== want.param_byte ||
        got.packet_id !== want.packet_id || got.instruction !== want.instruction ||
        got.frame_length !== want.frame_length || got.param_count !== want.param_count ||
        got.status !== want.status) begin
      bad_count++;
      if (bad_count <= 10) begin
        $display("ERROR: result mismatch at %0t", $realtime);
        $display("  expected %s", fmt(want));
        $display("  actual   %s", fmt(got));
      end
    end
  endfunction
endclass

module servo_bus_packet_deframer_tb;

  localparam int NumRegs     = 5;     // indexes at or above this are not decoded
  localparam int MaxGap      = 17;
  localparam int RandomItems = 1550;
  localparam int PhaseCount  = 5;     // register settings the random traffic runs under
  localparam int DrainCycles = 8;

  logic                clk;
  logic                rst;
  logic                write_en;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] write_data;

  sbd_in_if  rx_ch ();
  sbd_out_if res_ch ();

  servo_bus_packet_deframer DUT (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .rx         (rx_ch),
    .result     (res_ch)
  );

  deframe_scoreboard sb;

  logic [7:0] param_q [$];    // wire parameter bytes of the frame being built
  logic [7:0] frame_q [$];    // whole frame, header through CRC
  int         items_sent = 0;
  int         settings_used = 0;
  int         send_calm = 0;  // transactions left in a no-idle stretch, sender side
  int         sink_calm = 0;  // same for the result side

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well past the slowest legal run, with every gap at max.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Idle cycles before the next transaction: mostly uniform 0..MaxGap, with
  // occasional stretches at full rate.
  function automatic int pick_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, MaxGap);
  endfunction

  // Input monitor: every accepted transaction goes to the predictor at its edge.
  // Signals are read in the active region, so they hold their pre-edge values.
  always @(posedge clk) begin
    if (!rst && rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) begin
      sb.take_rx_item(in_kind_t'(rx_ch.kind), rx_ch.rx_byte);
    end
  end

  // Result monitor: compare each accepted result with the oldest one due.
  always @(posedge clk) begin : result_mon
    deframe_result_t got;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.kind = res_kind_t'(res_ch.result_kind);
      got.param_byte = res_ch.param_byte;
      got.packet_id = res_ch.packet_id;
      got.instruction = res_ch.instruction;
      got.frame_length = res_ch.frame_length;
      got.param_count = res_ch.param_count;
      got.status = status_t'(res_ch.status);
      sb.check_result(got);
    end
  end

  // Result side: after each accepted result, drop ready for a random stall.
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap(sink_calm);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  // One input transaction. Called at a rising edge; returns at the accepting
  // edge with valid still high, so back-to-back items keep valid asserted.
  task automatic send_item(in_kind_t k, logic [7:0] b);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.kind    <= k;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Stop sending and wait until every due result has come back, then let the
  // pipeline empty of items that produce nothing (header bytes, CRC low byte).
  task automatic drain_block();
    rx_ch.valid <= 1'b0;
    repeat (4) @(posedge clk);   // last transaction has reached the predictor
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register write; write_en is left high so writes can run back to back.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    reg_index  <= idx;
    write_data <= data;
    write_en   <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Full register setting. Byte registers get junk in the upper data bits,
  // and the undecoded indexes get a write that must change nothing.
  task automatic apply_config(logic [7:0] h0, logic [7:0] h1, logic [7:0] h2,
                              logic [7:0] h3, logic [15:0] poly);
    logic [7:0] junk [4];
    foreach (junk[i]) junk[i] = 8'($urandom);
    for (int i = NumRegs; i < (1 << CfgIdxW); i++) begin
      write_reg(i[CfgIdxW-1:0], CfgDataW'($urandom));
    end
    write_reg(REG_HEADER_BYTE0, {junk[0], h0});
    write_reg(REG_HEADER_BYTE1, {junk[1], h1});
    write_reg(REG_HEADER_BYTE2, {junk[2], h2});
    write_reg(REG_HEADER_BYTE3, {junk[3], h3});
    write_reg(REG_CRC_POLY, poly);
    write_en <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Parameter bytes biased toward the repeat and stuff values so that runs,
  // saturation and stuff drops all show up often.
  task automatic fill_params(int n);
    int r;
    param_q.delete();
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) param_q.push_back(sb.hdr[0]);
      else if (r < 55) param_q.push_back(sb.hdr[2]);
      else param_q.push_back(8'($urandom));
    end
  endtask

  // Frame from the current header setting and param_q, CRC optionally broken.
  task automatic build_frame(logic [7:0] id, logic [7:0] instr, logic [15:0] len,
                             bit corrupt);
    logic [15:0] crc;
    frame_q.delete();
    for (int i = 0; i < 4; i++) frame_q.push_back(sb.hdr[i]);
    frame_q.push_back(id);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(instr);
    foreach (param_q[i]) frame_q.push_back(param_q[i]);
    crc = 16'h0000;
    foreach (frame_q[i]) crc = crc16_next(crc, frame_q[i], sb.poly);
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  task automatic send_frame(int n);
    for (int i = 0; i < n; i++) send_item(KIND_BYTE, frame_q[i]);
  endtask

  // Directed opening under the reset setting.
  task automatic send_directed();
    logic [7:0] stuffed [8];
    send_item(KIND_TIMEOUT, 8'hFF);          // timeout with nothing received
    send_item(KIND_BYTE, 8'h00);             // wrong first header byte
    send_item(KIND_BYTE, sb.hdr[0]);         // header good up to the reserved byte
    send_item(KIND_BYTE, sb.hdr[1]);
    send_item(KIND_BYTE, sb.hdr[2]);
    send_item(KIND_BYTE, ~sb.hdr[3]);
    // Two stuff drops, one after a run of three repeat bytes (count saturates).
    stuffed = '{8'hFF, 8'hFF, 8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFD, 8'h00};
    param_q.delete();
    foreach (stuffed[i]) param_q.push_back(stuffed[i]);
    build_frame(8'h00, 8'hFF, 16'd11, 1'b0);
    send_frame(frame_q.size());
  endtask

  // One random frame or disturbance. Every branch ends with an end report,
  // so the next one starts while the block is hunting.
  task automatic send_random_frame();
    int          pick;
    int          n;
    int          r;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 97 && pick >= 88) begin
      if (pick < 94) begin
        // line noise, then a timeout to resynchronize
        repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, 8'($urandom));
      end
      send_item(KIND_TIMEOUT, 8'($urandom));
    end else if (pick >= 80 && pick < 88) begin
      // header broken after 0..3 good bytes
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) send_item(KIND_BYTE, sb.hdr[i]);
      send_item(KIND_BYTE, sb.hdr[n] ^ 8'($urandom_range(1, 255)));
    end else if (pick >= 97) begin
      // length field up to the maximum, cut short by a timeout
      n = $urandom_range(0, 6);
      fill_params(n);
      len = 16'($urandom_range(n + 4, 65535));
      if ($urandom_range(0, 3) == 0) len = 16'hFFFF;
      build_frame(8'($urandom), 8'($urandom), len, 1'b0);
      send_frame(8 + n);
      send_item(KIND_TIMEOUT, 8'($urandom));
    end else begin
      // frame, some with a broken CRC or cut short: mostly short, rarely past 255 in length
      r = $urandom_range(0, 99);
      if (r < 2) n = $urandom_range(253, 262);
      else if (r < 20) n = 0;
      else n = $urandom_range(1, 12);
      fill_params(n);
      len = (n == 0) ? 16'($urandom_range(0, 3)) : 16'(n + 3);
      build_frame(8'($urandom), 8'($urandom), len, pick >= 55 && pick < 70);
      if (pick < 70) begin
        send_frame(frame_q.size());
      end else begin
        // truncated anywhere before the last CRC byte
        send_frame($urandom_range(1, frame_q.size() - 1));
        send_item(KIND_TIMEOUT, 8'($urandom));
      end
    end
  endtask

  task automatic run_traffic(int quota);
    int target;
    target = items_sent + quota;
    while (items_sent < target) send_random_frame();
  endtask

  initial begin
    logic [7:0] h0;
    sb = new();
    rst           = 1'b1;
    write_en      = 1'b0;
    reg_index     = '0;
    write_data    = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.kind    = KIND_BYTE;
    rx_ch.rx_byte = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: directed cases, then random traffic.
    settings_used = 1;
    send_directed();
    run_traffic(RandomItems / PhaseCount);
    drain_block();

    // Low extreme: all-zero header, zero polynomial (CRC stays zero).
    apply_config(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
    run_traffic(RandomItems / PhaseCount);
    drain_block();

    // High extreme: repeat byte equals stuff byte, so the stuff test wins.
    apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    run_traffic(RandomItems / PhaseCount);
    drain_block();

    // Random header and polynomial; half the time stuff byte equals repeat byte.
    h0 = 8'($urandom);
    apply_config(h0, 8'($urandom), ($urandom_range(0, 1) != 0) ? h0 : 8'($urandom),
                 8'($urandom), 16'($urandom));
    run_traffic(RandomItems / PhaseCount);
    drain_block();

    // Standard header again with a random polynomial.
    apply_config(HeaderByte0Rst, HeaderByte1Rst, HeaderByte2Rst, HeaderByte3Rst,
                 16'($urandom));
    run_traffic(RandomItems / PhaseCount);
    drain_block();

    $display("Sent %0d input transactions under %0d register settings", items_sent,
             settings_used);
    $display("Checked %0d parameters; end reports ok/timeout/header/crc: %0d/%0d/%0d/%0d",
             sb.param_seen, sb.status_seen[ST_OK], sb.status_seen[ST_TIMEOUT],
             sb.status_seen[ST_HEADER], sb.status_seen[ST_CHECKSUM]);
    if (sb.bad_count == 0 && sb.due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
